@@ hdl/cmfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfd_pkg
// shared types and codes of the extended crsf / msp frame decoder
// ----------------------------------------------------------------------------
package cmfd_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // reject reasons
   localparam logic [1:0] REASON_TYPE    = 2'd0;
   localparam logic [1:0] REASON_STATUS  = 2'd1;
   localparam logic [1:0] REASON_VERSION = 2'd2;
   localparam logic [1:0] REASON_LENGTH  = 2'd3;

   // parse phases
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   // msp status byte
   localparam logic [7:0] ST_ERROR    = 8'h80;
   localparam logic [7:0] ST_START    = 8'h10;
   localparam logic [1:0] ST_VER_MASK = 2'h3;
   localparam logic [1:0] VER_1       = 2'd1;
   localparam logic [1:0] VER_2       = 2'd2;

   // msp header lengths
   localparam logic [2:0] HDR_V1 = 3'd3;
   localparam logic [2:0] HDR_V2 = 3'd6;

   // byte positions inside the frame (address byte is position 0)
   localparam int         POS_W      = 4;
   localparam logic [3:0] POS_SIZE   = 4'd1;
   localparam logic [3:0] POS_TYPE   = 4'd2;
   localparam logic [3:0] POS_DEST   = 4'd3;
   localparam logic [3:0] POS_ORIGIN = 4'd4;
   localparam logic [3:0] POS_STATUS = 4'd5;

   // register indexes
   localparam int         CSR_INDEX_W   = 3;
   localparam logic [2:0] REG_RELAY     = 3'd0;
   localparam logic [2:0] REG_REQ_TYPE  = 3'd1;
   localparam logic [2:0] REG_WR_TYPE   = 3'd2;
   localparam logic [2:0] REG_PAY_LIMIT = 3'd3;
   localparam logic [2:0] REG_OVERHEAD  = 3'd4;

   // register reset values
   localparam logic       RST_RELAY     = 1'b1;
   localparam logic [7:0] RST_REQ_TYPE  = 8'd122;
   localparam logic [7:0] RST_WR_TYPE   = 8'd124;
   localparam logic [7:0] RST_PAY_LIMIT = 8'd64;
   localparam logic [3:0] RST_OVERHEAD  = 4'd4;

   typedef struct packed {
      logic       relay_enable;
      logic [7:0] request_frame_type;
      logic [7:0] write_frame_type;
      logic [7:0] payload_limit;
      logic [3:0] extended_overhead;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] msp_function;
      logic [7:0]  msp_flags;
      logic [7:0]  payload_length;
      logic        last_of_frame;
      logic [1:0]  reject_reason;
   } result_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] bytes_remaining;
   } status_type;

endpackage
`default_nettype wire

@@ hdl/cmfd_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfd_csr
// configuration registers of the frame decoder
// ----------------------------------------------------------------------------
module cmfd_csr
   import cmfd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [CSR_INDEX_W-1:0] wr_index,
   input  wire logic [7:0]             wr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_RELAY:     cfg_in.relay_enable       = wr_data[0];
            REG_REQ_TYPE:  cfg_in.request_frame_type = wr_data;
            REG_WR_TYPE:   cfg_in.write_frame_type   = wr_data;
            REG_PAY_LIMIT: cfg_in.payload_limit      = wr_data;
            REG_OVERHEAD:  cfg_in.extended_overhead  = wr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.relay_enable       <= RST_RELAY;
         cfg_ff.request_frame_type <= RST_REQ_TYPE;
         cfg_ff.write_frame_type   <= RST_WR_TYPE;
         cfg_ff.payload_limit      <= RST_PAY_LIMIT;
         cfg_ff.extended_overhead  <= RST_OVERHEAD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ hdl/cmfd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfd_parser
// byte-wide frame parser: position counter, header capture and checks
// ----------------------------------------------------------------------------
module cmfd_parser
   import cmfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       byte_valid,
   input  wire logic [7:0] rx_byte,
   input  wire logic       frame_start,
   output logic            res_valid,
   output result_type      res,
   output status_type      status
);

   logic [1:0]       phase_ff,     phase_in;
   logic [POS_W-1:0] pos_ff,       pos_in;
   logic [7:0]       frame_len_ff, frame_len_in;
   logic [2:0]       hdr_len_ff,   hdr_len_in;
   logic [7:0]       flags_ff,     flags_in;
   logic [15:0]      func_ff,      func_in;
   logic [7:0]       size_ff,      size_in;
   logic [7:0]       remain_ff,    remain_in;

   logic [2:0]  hdr_idx;
   logic        hdr_done;
   logic [15:0] size_full;
   logic [9:0]  need_len;
   logic [1:0]  version;

   always_comb begin
      hdr_idx   = 3'(pos_ff - POS_STATUS);
      version   = rx_byte[6:5] & ST_VER_MASK;
      size_full = (hdr_len_ff == HDR_V2) ? {rx_byte, size_ff} : {8'd0, size_ff};
      // header plus payload plus overhead plus one must fit in the frame size
      need_len  = 10'(hdr_len_ff) + 10'(size_ff) + 10'(cfg.extended_overhead) + 10'd1;
      hdr_done  = (4'(hdr_idx) + 4'd1) >= 4'(hdr_len_ff);

      phase_in     = phase_ff;
      pos_in       = pos_ff;
      frame_len_in = frame_len_ff;
      hdr_len_in   = hdr_len_ff;
      flags_in     = flags_ff;
      func_in      = func_ff;
      size_in      = size_ff;
      remain_in    = remain_ff;
      res_valid    = 1'b0;
      res          = '0;

      if (byte_valid) begin
         if (frame_start) begin
            // a new frame aborts whatever was in progress
            phase_in     = cfg.relay_enable ? PH_HEADER : PH_IDLE;
            pos_in       = POS_SIZE;
            frame_len_in = '0;
            hdr_len_in   = '0;
            flags_in     = '0;
            func_in      = '0;
            size_in      = '0;
            remain_in    = '0;
         end else begin
            case (phase_ff)
               PH_PAYLOAD: begin
                  res_valid            = 1'b1;
                  res.kind             = KIND_DATA;
                  res.data_byte        = rx_byte;
                  res.msp_function     = func_ff;
                  res.msp_flags        = flags_ff;
                  res.payload_length   = size_ff;
                  res.last_of_frame    = (remain_ff <= 8'd1);
                  if (remain_ff > 8'd1) begin
                     remain_in = remain_ff - 8'd1;
                  end else begin
                     remain_in = '0;
                     phase_in  = PH_IDLE;
                  end
               end
               PH_HEADER: begin
                  if (pos_ff != '1) pos_in = pos_ff + 1'b1;
                  case (pos_ff)
                     POS_SIZE: frame_len_in = rx_byte;
                     POS_TYPE: begin
                        if (rx_byte != cfg.request_frame_type &&
                            rx_byte != cfg.write_frame_type) begin
                           res_valid         = 1'b1;
                           res.kind          = KIND_REJECT;
                           res.reject_reason = REASON_TYPE;
                           phase_in          = PH_IDLE;
                        end
                     end
                     POS_DEST, POS_ORIGIN: ;
                     POS_STATUS: begin
                        if ((rx_byte & ST_ERROR) != 8'd0 || (rx_byte & ST_START) == 8'd0) begin
                           res_valid         = 1'b1;
                           res.kind          = KIND_REJECT;
                           res.reject_reason = REASON_STATUS;
                           phase_in          = PH_IDLE;
                        end else if (version == VER_1) begin
                           hdr_len_in = HDR_V1;
                        end else if (version == VER_2) begin
                           hdr_len_in = HDR_V2;
                        end else begin
                           res_valid         = 1'b1;
                           res.kind          = KIND_REJECT;
                           res.reject_reason = REASON_VERSION;
                           phase_in          = PH_IDLE;
                        end
                     end
                     default: begin
                        // msp header bytes
                        if (hdr_len_ff == HDR_V1) begin
                           case (hdr_idx)
                              3'd1: size_in = rx_byte;
                              3'd2: func_in = {8'd0, rx_byte};
                              default: ;
                           endcase
                        end else begin
                           case (hdr_idx)
                              3'd1: flags_in = rx_byte;
                              3'd2: func_in  = {8'd0, rx_byte};
                              3'd3: func_in  = {rx_byte, func_ff[7:0]};
                              3'd4: size_in  = rx_byte;
                              default: ;
                           endcase
                        end
                        if (hdr_done) begin
                           res_valid = 1'b1;
                           if (size_full > {8'd0, cfg.payload_limit} ||
                               need_len > 10'(frame_len_ff)) begin
                              res.kind          = KIND_REJECT;
                              res.reject_reason = REASON_LENGTH;
                              phase_in          = PH_IDLE;
                           end else begin
                              res.kind           = KIND_HEADER;
                              res.msp_function   = func_in;
                              res.msp_flags      = flags_ff;
                              res.payload_length = size_ff;
                              res.last_of_frame  = (size_ff == 8'd0);
                              remain_in          = size_ff;
                              phase_in = (size_ff == 8'd0) ? PH_IDLE : PH_PAYLOAD;
                           end
                        end
                     end
                  endcase
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         frame_len_ff <= '0;
         hdr_len_ff   <= '0;
         flags_ff     <= '0;
         func_ff      <= '0;
         size_ff      <= '0;
         remain_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         frame_len_ff <= frame_len_in;
         hdr_len_ff   <= hdr_len_in;
         flags_ff     <= flags_in;
         func_ff      <= func_in;
         size_ff      <= size_in;
         remain_ff    <= remain_in;
      end
   end

   assign status.phase           = phase_ff;
   assign status.bytes_remaining = remain_ff;

endmodule
`default_nettype wire

@@ hdl/cmfd_out_skid.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfd_out_skid
// result register with one skid entry behind it
// ----------------------------------------------------------------------------
module cmfd_out_skid
   import cmfd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire result_type in_data,
   output logic      in_ready,
   output logic      out_valid,
   input  wire logic out_ready,
   output result_type out_data,
   output logic      skid_full
);

   logic       out_valid_ff,  out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff,   out_data_in;
   result_type skid_data_ff,  skid_data_in;
   logic       load;

   always_comb begin
      load          = !out_valid_ff || out_ready;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (load) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign skid_full = skid_valid_ff;

endmodule
`default_nettype wire

@@ hdl/crsf_msp_frame_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_msp_frame_decoder
// decodes msp messages carried in extended crsf frames, one byte at a time
// ----------------------------------------------------------------------------
//
//  channel | direction | contents
//  --------+-----------+-------------------------------------------------------
//  req_    | in        | frame bytes, tuser marks the address byte of a frame
//  rsp_    | out       | header, payload byte or reject, tlast ends a frame
//  csr_    | in        | register writes, index and data, always ready
//
//  one byte per clock while req_tready is high: the parser updates its
//  position counter and header fields in the same cycle the byte is taken;
//  the result is registered in the output register, or in its one skid
//  entry while the output register holds a stalled result; req_tready drops
//  only while that entry is occupied, i.e. after the consumer has stalled
//  two results; reset is synchronous, active high, and idles the parser with
//  all registers at their default values
//
module crsf_msp_frame_decoder
   import cmfd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input byte stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] rx_byte
   input  wire logic                   req_tuser,   // [0] frame_start
   // result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [7:0] data_byte, [23:8] msp_function, [31:24] msp_flags,
   // [39:32] payload_length, [41:40] reject_reason, [47:42] zero
   output logic [47:0]                 rsp_tdata,
   output logic [1:0]                  rsp_tuser,   // [1:0] kind
   output logic                        rsp_tlast,   // last_of_frame
   // configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_data
);

   cfg_type    cfg;
   result_type parse_res;
   result_type out_res;
   status_type parse_status;
   logic       parse_valid;
   logic       byte_accept;
   logic       skid_full;

   // registers take a write every cycle
   assign csr_ready = 1'b1;

   cmfd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // a byte transaction completes whenever the skid entry is free
   assign byte_accept = req_tvalid && req_tready;

   cmfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .byte_valid  (byte_accept),
      .rx_byte     (req_tdata),
      .frame_start (req_tuser),
      .res_valid   (parse_valid),
      .res         (parse_res),
      .status      (parse_status)
   );

   cmfd_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (parse_valid),
      .in_data   (parse_res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res),
      .skid_full (skid_full)
   );

   // pack the result fields onto the stream
   assign rsp_tdata = {6'd0, out_res.reject_reason, out_res.payload_length,
                       out_res.msp_flags, out_res.msp_function, out_res.data_byte};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last_of_frame;

`ifndef SYNTHESIS
   // an occupied skid entry always sits behind a valid output
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_tvalid)
      else $error("skid entry held without a valid output");

   // payload phase never runs with an exhausted byte count
   a_payload_count : assert property (@(posedge clock) disable iff (reset)
      (parse_status.phase == PH_PAYLOAD) |-> (parse_status.bytes_remaining != 8'd0))
      else $error("payload phase with zero bytes remaining");

   // a rejected frame never ends with a frame-last marker
   a_reject_no_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_REJECT) |-> !rsp_tlast)
      else $error("reject result marked last");

   // the address byte of a frame never yields a result
   a_start_silent : assert property (@(posedge clock) disable iff (reset)
      (byte_accept && req_tuser) |-> !parse_valid)
      else $error("result produced on a frame start byte");
`endif

endmodule
`default_nettype wire

@@ test/crsf_msp_frame_decoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_msp_frame_decoder_checker
// follows the byte stream and the register writes, decodes every frame on its
// own and compares each result transaction with the oldest decoded result
// ----------------------------------------------------------------------------
module crsf_msp_frame_decoder_checker
   import cmfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] rx_byte
   input  logic                   req_tuser,   // [0] frame_start
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] data_byte, [23:8] msp_function, [31:24] msp_flags,
   // [39:32] payload_length, [41:40] reject_reason, [47:42] zero
   input  logic [47:0]            rsp_tdata,
   input  logic [1:0]             rsp_tuser,   // [1:0] kind
   input  logic                   rsp_tlast,   // last_of_frame
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data,
   output int                     error_count,
   output int                     decoded_pending,
   output int                     result_count,
   output int                     reject_count
);

   cfg_type     cfg;
   logic [1:0]  phase;
   logic [7:0]  position;
   logic [7:0]  frame_len;
   logic [2:0]  header_len;
   logic [7:0]  flags;
   logic [15:0] func;
   logic [15:0] msp_size;
   logic [7:0]  remaining;
   result_type  decoded_queue[$];

   task automatic clear_frame();
      phase      = PH_IDLE;
      position   = '0;
      frame_len  = '0;
      header_len = '0;
      flags      = '0;
      func       = '0;
      msp_size   = '0;
      remaining  = '0;
   endtask

   function automatic result_type rejection(input logic [1:0] reason);
      result_type r;
      r = '0;
      r.kind = KIND_REJECT;
      r.reject_reason = reason;
      phase = PH_IDLE;
      return r;
   endfunction

   // decodes one byte, updates the frame state, tells whether a result follows
   task automatic decode_byte(input logic [7:0] b, input logic start,
                              output bit produced, output result_type res);
      logic [7:0] pos;
      logic [7:0] p;
      logic [1:0] ver;
      int         avail;
      produced = 1'b0;
      res = '0;
      if (start) begin
         clear_frame();
         phase = cfg.relay_enable ? PH_HEADER : PH_IDLE;
         position = 8'd1;
      end else if (phase == PH_PAYLOAD) begin
         res.kind = KIND_DATA;
         res.data_byte = b;
         res.msp_function = func;
         res.msp_flags = flags;
         res.payload_length = msp_size[7:0];
         res.last_of_frame = (remaining <= 8'd1);
         produced = 1'b1;
         if (remaining > 8'd0) remaining--;
         if (remaining == 8'd0) phase = PH_IDLE;
      end else if (phase == PH_HEADER) begin
         pos = position;
         if (position < 8'd255) position++;
         if (pos == POS_SIZE) begin
            frame_len = b;
         end else if (pos == POS_TYPE) begin
            if (b != cfg.request_frame_type && b != cfg.write_frame_type) begin
               res = rejection(REASON_TYPE);
               produced = 1'b1;
            end
         end else if (pos == POS_STATUS) begin
            ver = b[6:5] & ST_VER_MASK;
            produced = 1'b1;
            if ((b & ST_ERROR) != 8'd0 || (b & ST_START) == 8'd0)
               res = rejection(REASON_STATUS);
            else if (ver == VER_1) begin
               header_len = HDR_V1;
               produced = 1'b0;
            end else if (ver == VER_2) begin
               header_len = HDR_V2;
               produced = 1'b0;
            end else
               res = rejection(REASON_VERSION);
         end else if (pos > POS_STATUS) begin
            p = pos - POS_STATUS;
            // v1: size, function; v2: flags, function lo/hi, size lo/hi
            if (header_len == HDR_V1) begin
               if (p == 8'd1) msp_size = {8'd0, b};
               else if (p == 8'd2) func = {8'd0, b};
            end else begin
               if (p == 8'd1) flags = b;
               else if (p == 8'd2) func = {8'd0, b};
               else if (p == 8'd3) func[15:8] = b;
               else if (p == 8'd4) msp_size = {8'd0, b};
               else if (p == 8'd5) msp_size[15:8] = b;
            end
            if (int'(p) + 1 >= int'(header_len)) begin
               produced = 1'b1;
               avail = int'(frame_len) - int'(cfg.extended_overhead) - 1;
               if (msp_size > {8'd0, cfg.payload_limit} ||
                   int'(header_len) + int'(msp_size) > avail) begin
                  res = rejection(REASON_LENGTH);
               end else begin
                  res.kind = KIND_HEADER;
                  res.msp_function = func;
                  res.msp_flags = flags;
                  res.payload_length = msp_size[7:0];
                  res.last_of_frame = (msp_size == 16'd0);
                  if (msp_size == 16'd0) begin
                     phase = PH_IDLE;
                  end else begin
                     remaining = msp_size[7:0];
                     phase = PH_PAYLOAD;
                  end
               end
            end
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      result_type decoded;
      bit         produced;
      if (reset) begin
         cfg = '{relay_enable: RST_RELAY, request_frame_type: RST_REQ_TYPE,
                 write_frame_type: RST_WR_TYPE, payload_limit: RST_PAY_LIMIT,
                 extended_overhead: RST_OVERHEAD};
         clear_frame();
         decoded_queue.delete();
         error_count = 0;
         decoded_pending = 0;
         result_count = 0;
         reject_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RELAY:     cfg.relay_enable       = csr_data[0];
               REG_REQ_TYPE:  cfg.request_frame_type = csr_data;
               REG_WR_TYPE:   cfg.write_frame_type   = csr_data;
               REG_PAY_LIMIT: cfg.payload_limit      = csr_data;
               REG_OVERHEAD:  cfg.extended_overhead  = csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind           = rsp_tuser;
            got.data_byte      = rsp_tdata[7:0];
            got.msp_function   = rsp_tdata[23:8];
            got.msp_flags      = rsp_tdata[31:24];
            got.payload_length = rsp_tdata[39:32];
            got.reject_reason  = rsp_tdata[41:40];
            got.last_of_frame  = rsp_tlast;
            result_count++;
            if (got.kind == KIND_REJECT) reject_count++;
            if (decoded_queue.size() == 0) begin
               error_count++;
               $display("%0t ns: unexpected result, expected none, actual kind %0d tdata %h",
                        $time, got.kind, rsp_tdata);
            end else begin
               want = decoded_queue.pop_front();
               compare_field("kind", 16'(want.kind), 16'(got.kind));
               compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
               compare_field("msp_function", want.msp_function, got.msp_function);
               compare_field("msp_flags", 16'(want.msp_flags), 16'(got.msp_flags));
               compare_field("payload_length", 16'(want.payload_length),
                             16'(got.payload_length));
               compare_field("last_of_frame", 16'(want.last_of_frame),
                             16'(got.last_of_frame));
               compare_field("reject_reason", 16'(want.reject_reason),
                             16'(got.reject_reason));
            end
            compare_field("tdata padding", 16'd0, 16'(rsp_tdata[47:42]));
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tuser, produced, decoded);
            if (produced) decoded_queue.push_back(decoded);
         end
         decoded_pending = decoded_queue.size();
      end
   end

endmodule

@@ test/crsf_msp_frame_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_msp_frame_decoder_test
// drives extended crsf frames carrying msp messages into the decoder under
// several register settings, with random gaps and stalls on both streams;
// the checker beside the block decodes the same bytes and compares results
// ----------------------------------------------------------------------------
module crsf_msp_frame_decoder_test;
   import cmfd_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000; // far above the slowest legal run
   localparam int HOLD_CYCLES  = 400;       // long consumer stall, fills the skid
   localparam int DRAIN_CYCLES = 8;         // margin once no decoded result is outstanding
   localparam int MAX_GAP      = 19;

   // status version fields the block must refuse
   localparam logic [1:0] BAD_VER_LOW  = 2'd0;
   localparam logic [1:0] BAD_VER_HIGH = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;   // [7:0] rx_byte
   logic                   req_tuser = 1'b0; // [0] frame_start
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] data_byte, [23:8] msp_function, [31:24] msp_flags,
   // [39:32] payload_length, [41:40] reject_reason, [47:42] zero
   logic [47:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;        // [1:0] kind
   logic                   rsp_tlast;        // last_of_frame
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_data = '0;

   int error_count;
   int decoded_pending;
   int result_count;
   int reject_count;

   int         cycle_count = 0;
   cfg_type    settings;           // what the registers currently hold
   logic [7:0] frame_buf[$];       // bytes of the frame being sent
   bit         rsp_hold_request = 1'b0;
   bit         send_burst = 1'b0;  // no gaps between bytes while set
   int         frame_bytes = 0;    // bytes of relayed frames sent so far
   int         frames_sent = 0;
   int         settings_tried = 0;

   crsf_msp_frame_decoder u_dut (.*);

   crsf_msp_frame_decoder_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // result side: random stall before each transaction, runs without stalls,
   // and one long hold when the stimulus asks for it
   // ---------------------------------------------------------------------------
   initial begin : consumer
      int stall;
      int burst_left;
      burst_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_request) begin
            // hold counted here, the sender keeps offering bytes meanwhile
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold_request = 1'b0;
         end
         if (burst_left > 0) begin
            stall = 0;
            burst_left--;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(20, 80);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------------
   // byte side helpers; every task is entered and left at a falling edge
   // ---------------------------------------------------------------------------

   // one byte transaction, preceded by a random gap unless bursting
   task automatic send_byte(input logic [7:0] value, input logic start);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // let the block drain: no byte offered, nothing outstanding, then a margin
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (decoded_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // register write transaction; csr_valid is left high for a following write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // only between phases, with the decoder idle
   task automatic apply_settings(input cfg_type s);
      quiesce();
      write_reg(REG_RELAY, 8'(s.relay_enable));
      write_reg(REG_REQ_TYPE, s.request_frame_type);
      write_reg(REG_WR_TYPE, s.write_frame_type);
      write_reg(REG_PAY_LIMIT, s.payload_limit);
      write_reg(REG_OVERHEAD, 8'(s.extended_overhead));
      csr_valid <= 1'b0;
      settings = s;
      settings_tried++;
   endtask

   // well-formed msp status byte: start bit, version, random sequence number
   function automatic logic [7:0] msp_status(input logic [1:0] ver);
      logic [7:0] seq;
      seq = 8'($urandom_range(0, 15));
      return ST_START | {1'b0, ver, 5'd0} | seq;
   endfunction

   // assembles a whole frame in frame_buf; slack moves the frame size byte
   // away from the tightest size that still fits the payload
   task automatic build_frame(input logic [7:0] frame_type, input logic [7:0] status,
                              input bit v2, input logic [15:0] func,
                              input logic [7:0] flags, input logic [15:0] size,
                              input int slack);
      int hdr;
      int fl;
      int n;
      hdr = v2 ? int'(HDR_V2) : int'(HDR_V1);
      fl = hdr + int'(size) + int'(settings.extended_overhead) + 1 + slack;
      if (fl > 255) fl = 255;
      if (fl < 0) fl = 0;
      frame_buf.delete();
      frame_buf.push_back(8'($urandom));     // address
      frame_buf.push_back(8'(fl));
      frame_buf.push_back(frame_type);
      frame_buf.push_back(8'($urandom));     // destination
      frame_buf.push_back(8'($urandom));     // origin
      frame_buf.push_back(status);
      if (v2) begin
         frame_buf.push_back(flags);
         frame_buf.push_back(func[7:0]);
         frame_buf.push_back(func[15:8]);
         frame_buf.push_back(size[7:0]);
         frame_buf.push_back(size[15:8]);
      end else begin
         frame_buf.push_back(size[7:0]);
         frame_buf.push_back(func[7:0]);
      end
      // an oversized declared payload is only partly sent, it gets rejected
      n = (size > 16'd255) ? 3 : int'(size);
      repeat (n) frame_buf.push_back(8'($urandom));
      frame_buf.push_back(8'($urandom));     // crc, ignored by the block
   endtask

   // sends the first count bytes of frame_buf, frame start on the first
   task automatic send_frame(input int count);
      int sent;
      sent = 0;
      for (int i = 0; i < count && i < frame_buf.size(); i++) begin
         send_byte(frame_buf[i], i == 0);
         sent++;
      end
      frames_sent++;
      if (settings.relay_enable) frame_bytes += sent;
   endtask

   // mostly well-formed frames with random content, the rest broken or noise
   task automatic random_frame();
      int          pick;
      logic [7:0]  ftype;
      logic [7:0]  status;
      bit          v2;
      logic [15:0] size;
      int          top_size;
      int          slack;
      int          count;
      pick = $urandom_range(0, 99);
      send_burst = ($urandom_range(0, 4) == 0);
      ftype = $urandom_range(0, 1) ? settings.request_frame_type
                                   : settings.write_frame_type;
      if (pick < 6) ftype = 8'($urandom);
      v2 = $urandom_range(0, 1);
      status = msp_status(v2 ? VER_2 : VER_1);
      if (pick >= 6 && pick < 12) status = 8'($urandom);
      // small payloads mostly, now and then up to just past the limit
      top_size = int'(settings.payload_limit) + 2;
      if (top_size > 255) top_size = 255;
      if (pick < 80) size = 16'($urandom_range(0, 12));
      else size = 16'($urandom_range(0, top_size));
      if (v2 && pick >= 92 && pick < 96) size[15:8] = 8'($urandom_range(1, 255));
      slack = (pick >= 96) ? -$urandom_range(1, 3) : $urandom_range(0, 2);
      build_frame(ftype, status, v2, 16'($urandom), 8'($urandom), size, slack);
      // a frame cut short ends at the next frame start
      count = frame_buf.size();
      if ($urandom_range(0, 11) == 0) count = $urandom_range(1, frame_buf.size() - 1);
      send_frame(count);
      // stray bytes between frames
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b0);
      // raw noise, frame start bit included
      if ($urandom_range(0, 19) == 0)
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 49) == 0) quiesce();
      send_burst = 1'b0;
   endtask

   task automatic run_random(input int budget);
      int target;
      target = frame_bytes + budget;
      while (frame_bytes < target) random_frame();
   endtask

   function automatic cfg_type random_settings();
      cfg_type s;
      s.relay_enable       = 1'b1;
      s.request_frame_type = 8'($urandom);
      s.write_frame_type   = 8'($urandom);
      s.payload_limit      = 8'($urandom_range(0, 255));
      s.extended_overhead  = 4'($urandom_range(0, 15));
      return s;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      cfg_type s;
      settings = '{relay_enable: RST_RELAY, request_frame_type: RST_REQ_TYPE,
                   write_frame_type: RST_WR_TYPE, payload_limit: RST_PAY_LIMIT,
                   extended_overhead: RST_OVERHEAD};
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames under the reset settings
      // shortest accepted frame: v1, empty payload, header result is last
      build_frame(settings.request_frame_type, msp_status(VER_1), 1'b0, 16'h0000,
                  8'h00, 16'd0, 0);
      send_frame(frame_buf.size());
      // v2 write frame with all-ones function and flags
      build_frame(settings.write_frame_type, msp_status(VER_2), 1'b1, 16'hFFFF,
                  8'hFF, 16'd3, 0);
      send_frame(frame_buf.size());
      // payload exactly at the limit, then one byte over
      build_frame(settings.request_frame_type, msp_status(VER_1), 1'b0, 16'h00A5,
                  8'h00, 16'(settings.payload_limit), 0);
      send_frame(frame_buf.size());
      build_frame(settings.request_frame_type, msp_status(VER_1), 1'b0, 16'h005A,
                  8'h00, 16'(settings.payload_limit) + 16'd1, 0);
      send_frame(frame_buf.size());
      // frame size byte one short of the payload
      build_frame(settings.write_frame_type, msp_status(VER_2), 1'b1, 16'h1234,
                  8'h01, 16'd2, -1);
      send_frame(frame_buf.size());
      // v2 size with its high byte set
      build_frame(settings.write_frame_type, msp_status(VER_2), 1'b1, 16'h8001,
                  8'h80, 16'h0102, 0);
      send_frame(frame_buf.size());
      // frame type that is neither request nor write
      build_frame(settings.request_frame_type + 8'd1, msp_status(VER_1), 1'b0,
                  16'h0001, 8'h00, 16'd1, 0);
      send_frame(frame_buf.size());
      // status with the error bit, then without the start bit
      build_frame(settings.request_frame_type, msp_status(VER_1) | ST_ERROR, 1'b0,
                  16'h0002, 8'h00, 16'd1, 0);
      send_frame(frame_buf.size());
      build_frame(settings.request_frame_type, msp_status(VER_2) & ~ST_START, 1'b1,
                  16'h0003, 8'h00, 16'd1, 0);
      send_frame(frame_buf.size());
      // both unsupported versions
      build_frame(settings.request_frame_type, msp_status(BAD_VER_LOW), 1'b0,
                  16'h0004, 8'h00, 16'd1, 0);
      send_frame(frame_buf.size());
      build_frame(settings.write_frame_type, msp_status(BAD_VER_HIGH), 1'b1,
                  16'h0005, 8'h00, 16'd1, 0);
      send_frame(frame_buf.size());
      // bytes while idle are ignored
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // new frame start in the middle of a payload aborts the old frame
      build_frame(settings.request_frame_type, msp_status(VER_1), 1'b0, 16'h0077,
                  8'h00, 16'd8, 0);
      send_frame(10);
      build_frame(settings.write_frame_type, msp_status(VER_1), 1'b0, 16'h0078,
                  8'h00, 16'd2, 1);
      send_frame(frame_buf.size());

      // consumer holds off while a full-limit frame streams in back to back,
      // the skid fills and the byte stream must stall
      quiesce();
      rsp_hold_request = 1'b1;
      send_burst = 1'b1;
      build_frame(settings.request_frame_type, msp_status(VER_2), 1'b1, 16'($urandom),
                  8'($urandom), 16'(settings.payload_limit), 0);
      send_frame(frame_buf.size());
      send_burst = 1'b0;

      run_random(350);

      // extremes, first with relaying off: nothing may come out
      s = '{relay_enable: 1'b0, request_frame_type: 8'h00, write_frame_type: 8'hFF,
            payload_limit: 8'hFF, extended_overhead: 4'hF};
      apply_settings(s);
      repeat (12) random_frame();
      s.relay_enable = 1'b1;
      apply_settings(s);
      run_random(300);

      // opposite extremes: only empty payloads fit
      s = '{relay_enable: 1'b1, request_frame_type: 8'hFF, write_frame_type: 8'h00,
            payload_limit: 8'h00, extended_overhead: 4'h0};
      apply_settings(s);
      run_random(200);

      repeat (2) begin
         apply_settings(random_settings());
         run_random(350);
      end

      quiesce();
      $display("covered %0d frames (%0d relayed bytes) over %0d register settings",
               frames_sent, frame_bytes, settings_tried + 1);
      $display("checked %0d results, %0d of them rejects", result_count, reject_count);
      if (error_count == 0 && decoded_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
